// ----- hdl/dmcr_pkg.sv -----
package dmcr_pkg;

  // fixed field widths
  localparam int REG_W      = 16;
  localparam int SPEED_W    = 12;
  localparam int MSR_W      = 12;
  localparam int SP_W       = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_SHIFT = 11;

  localparam logic [SP_W-1:0] SETPOINT_MAX  = 10'd800;
  localparam logic [SP_W-1:0] SETPOINT_MIN  = 10'd100;
  localparam logic [SP_W-1:0] SETPOINT_STEP = 10'd10;

  localparam logic signed [MSR_W-1:0] FWD_SPEED = 12'sd2000;

  localparam logic [7:0] INV_SAFE  = 8'h00;
  localparam logic [7:0] INV_RUN   = 8'h30;
  localparam logic [7:0] INV_START = 8'h70;

  typedef enum logic [1:0] {
    BMS_IDLE,
    BMS_PRECHARGE,
    BMS_DRIVE,
    BMS_FAULT
  } bms_state_t;

  typedef enum logic [2:0] {
    DM_OFF,
    DM_PRECHARGE,
    DM_BRAKE,
    DM_CRUISE,
    DM_FORWARD,
    DM_REVERSE,
    DM_NEUTRAL
  } drive_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEDAL_LOW,
    CFG_PEDAL_HIGH,
    CFG_PEDAL_GAIN,
    CFG_RAMP_STEP,
    CFG_LOW_SPEED_CAP,
    CFG_LOW_SPEED_LIMIT,
    CFG_CRUISE_CURRENT
  } cfg_reg_t;

  // switch and status bits of one tick
  typedef struct packed {
    logic       key_on;
    bms_state_t bms;
    logic       regen;
    logic       brake;
    logic       engage;
    logic       up;
    logic       down;
    logic       fwd;
    logic       rev;
    logic       tick;
  } drv_sw_t;

endpackage

// ----- hdl/dmcr_step.sv -----
module dmcr_step
  import dmcr_pkg::*;
#(
  parameter int PEDAL_BITS    = 12,
  parameter int FRACTION_BITS = 15
) (
  input  drv_sw_t                    sw,
  input  logic [PEDAL_BITS-1:0]      pedal_sample,
  input  logic [SPEED_W-1:0]         vehicle_speed,
  input  logic [PEDAL_BITS-1:0]      pedal_low,
  input  logic [PEDAL_BITS-1:0]      pedal_high,
  input  logic [REG_W-1:0]           pedal_gain,
  input  logic [REG_W-1:0]           ramp_step,
  input  logic [REG_W-1:0]           low_speed_cap,
  input  logic [SPEED_W-1:0]         low_speed_limit,
  input  logic [REG_W-1:0]           cruise_current,
  input  logic                       cruise_latched,
  input  logic [SP_W-1:0]            cruise_setpoint,
  input  logic [FRACTION_BITS:0]     current_level,
  input  logic [FRACTION_BITS:0]     previous_target,
  input  logic signed [MSR_W-1:0]    speed_level,
  output logic                       cruise_latched_nxt,
  output logic [SP_W-1:0]            cruise_setpoint_nxt,
  output logic [FRACTION_BITS:0]     current_level_nxt,
  output logic [FRACTION_BITS:0]     previous_target_nxt,
  output logic signed [MSR_W-1:0]    speed_level_nxt,
  output logic [7:0]                 inverter_mode,
  output drive_mode_t                drive_mode
);

  localparam int CW = FRACTION_BITS + 1;
  localparam int PW = PEDAL_BITS + REG_W + 1;
  localparam int SW = PW - GAIN_SHIFT;
  localparam int TW = (SW > CW) ? SW : CW;
  localparam int DW = ((CW > REG_W) ? CW : REG_W) + 1;
  localparam logic [TW-1:0] ONE_T = TW'(1) << FRACTION_BITS;
  localparam logic [DW-1:0] ONE_D = DW'(1) << FRACTION_BITS;
  localparam logic [PW-1:0] ROUND = PW'(1) << (GAIN_SHIFT - 1);

  logic             latch_a, latch_b;
  logic [PEDAL_BITS-1:0] lvl_hi, lvl, span;
  logic [PW-1:0]    prod;
  logic [SW-1:0]    scaled;
  logic [CW-1:0]    target, cap_sat, cruise_sat, ramped, fwd_cur;
  logic [DW-1:0]    ramped_d;
  logic             ramp_ok;
  logic [SP_W-1:0]  sp_up, sp_dn;

  // pedal window, then rounded reciprocal scaling
  always_comb begin
    lvl_hi = (pedal_sample < pedal_high) ? pedal_sample : pedal_high;
    lvl    = (lvl_hi < pedal_low) ? pedal_low : lvl_hi;
    span   = lvl - pedal_low;
    prod   = PW'(span) * PW'(pedal_gain) + ROUND;
    scaled = prod[PW-1:GAIN_SHIFT];
    target = (TW'(scaled) > ONE_T) ? CW'(ONE_T) : CW'(scaled);
  end

  always_comb begin
    cap_sat    = (DW'(low_speed_cap) > ONE_D) ? CW'(ONE_D) : CW'(low_speed_cap);
    cruise_sat = (DW'(cruise_current) > ONE_D) ? CW'(ONE_D) : CW'(cruise_current);
    ramp_ok    = DW'(target) >= (DW'(previous_target) + DW'(ramp_step));
    ramped_d   = DW'(current_level) + DW'(ramp_step);
    ramped     = (ramped_d > ONE_D) ? CW'(ONE_D) : CW'(ramped_d);
    fwd_cur    = ramp_ok ? ramped : target;
    if ((DW'(fwd_cur) > DW'(low_speed_cap)) && (vehicle_speed <= low_speed_limit)) begin
      fwd_cur = cap_sat;
    end
  end

  always_comb begin
    sp_up = (sw.up && (cruise_setpoint < SETPOINT_MAX)) ?
            cruise_setpoint + SETPOINT_STEP : cruise_setpoint;
    sp_dn = (sw.down && (sp_up > SETPOINT_MIN)) ? sp_up - SETPOINT_STEP : sp_up;
  end

  // engage latches even when the drive logic is skipped
  assign latch_a = cruise_latched | sw.engage;
  assign latch_b = latch_a & ~((lvl > pedal_low) | sw.regen | sw.brake);

  always_comb begin
    cruise_latched_nxt  = latch_a;
    cruise_setpoint_nxt = cruise_setpoint;
    current_level_nxt   = current_level;
    previous_target_nxt = previous_target;
    speed_level_nxt     = speed_level;
    inverter_mode       = INV_SAFE;
    drive_mode          = DM_OFF;
    if (!sw.key_on) begin
      current_level_nxt = '0;
      speed_level_nxt   = '0;
    end else if (sw.bms inside {BMS_IDLE, BMS_PRECHARGE}) begin
      inverter_mode = INV_START;
      drive_mode    = DM_PRECHARGE;
    end else begin
      inverter_mode       = (sw.bms == BMS_DRIVE) ? INV_RUN : INV_SAFE;
      cruise_latched_nxt  = latch_b;
      cruise_setpoint_nxt = sp_dn;
      if (sw.regen) begin
        current_level_nxt = target;
        speed_level_nxt   = '0;
        drive_mode        = DM_BRAKE;
      end else if (latch_b && (sp_dn > SETPOINT_MIN)) begin
        current_level_nxt = cruise_sat;
        speed_level_nxt   = MSR_W'(sp_dn);
        drive_mode        = DM_CRUISE;
      end else if (sw.fwd) begin
        if (sw.tick) begin
          current_level_nxt   = fwd_cur;
          previous_target_nxt = target;
        end
        speed_level_nxt = FWD_SPEED;
        drive_mode      = DM_FORWARD;
      end else if (sw.rev) begin
        current_level_nxt = target;
        speed_level_nxt   = -FWD_SPEED;
        drive_mode        = DM_REVERSE;
      end else begin
        current_level_nxt = '0;
        speed_level_nxt   = '0;
        drive_mode        = DM_NEUTRAL;
      end
    end
  end

endmodule

// ----- hdl/drive_mode_current_reference.sv -----
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------------
// input     | in_valid / in_ready  | switches, bms state, pedal sample, speed
// result    | out_valid / out_ready| cur_ref, motor_speed_ref, modes
// config    | cfg_wr_en            | cfg_index, cfg_data (no read-back)
//
// one word per cycle sustained while out_ready is high; a word goes from the input
// register through one pass of the pedal multiply and mode mux into the result
// register, and waits in the input register while the result is not taken.
// synchronous active-low reset restores register defaults, clears valid and drive state.
// input is still taken while a result waits, until the input register is full.
module drive_mode_current_reference
  import dmcr_pkg::*;
#(
  parameter int PEDAL_BITS    = 12,
  parameter int FRACTION_BITS = 15
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_key_on,
  input  logic [1:0]              in_bms_state,
  input  logic [PEDAL_BITS-1:0]   in_pedal_sample,
  input  logic                    in_regen_brake,
  input  logic                    in_brake_pedal,
  input  logic                    in_cruise_engage,
  input  logic                    in_cruise_up,
  input  logic                    in_cruise_down,
  input  logic                    in_drive_forward,
  input  logic                    in_drive_reverse,
  input  logic                    in_limit_tick,
  input  logic [SPEED_W-1:0]      in_vehicle_speed,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRACTION_BITS:0]  out_cur_ref,
  output logic signed [MSR_W-1:0] out_motor_speed_ref,
  output logic [7:0]              out_inverter_mode,
  output logic [2:0]              out_drive_mode,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = FRACTION_BITS + 1;
  localparam logic [CW-1:0] ONE_Q = CW'(1) << FRACTION_BITS;

  // configuration
  logic [PEDAL_BITS-1:0] pedal_low_r, pedal_high_r;
  logic [REG_W-1:0]      pedal_gain_r, ramp_step_r, low_speed_cap_r, cruise_current_r;
  logic [SPEED_W-1:0]    low_speed_limit_r;

  // input stage
  logic                  in_vld_r;
  drv_sw_t               in_sw_r;
  logic [PEDAL_BITS-1:0] in_pedal_r;
  logic [SPEED_W-1:0]    in_speed_r;

  // drive state
  logic                  latched_r, latched_nxt;
  logic [SP_W-1:0]       setpoint_r, setpoint_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic [CW-1:0]         prev_tgt_r, prev_tgt_nxt;
  logic signed [MSR_W-1:0] spd_r, spd_nxt;

  logic [7:0]            inv_mode;
  drive_mode_t           dmode;
  logic                  move;

  assign move     = in_vld_r && (!out_valid || out_ready);
  assign in_ready = !in_vld_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pedal_low_r       <= PEDAL_BITS'(200);
      pedal_high_r      <= PEDAL_BITS'(3530);
      pedal_gain_r      <= 16'd20153;
      ramp_step_r       <= 16'd1638;
      low_speed_cap_r   <= 16'd16384;
      low_speed_limit_r <= 12'd200;
      cruise_current_r  <= 16'd6554;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PEDAL_LOW:       pedal_low_r       <= cfg_data[PEDAL_BITS-1:0];
        CFG_PEDAL_HIGH:      pedal_high_r      <= cfg_data[PEDAL_BITS-1:0];
        CFG_PEDAL_GAIN:      pedal_gain_r      <= cfg_data[REG_W-1:0];
        CFG_RAMP_STEP:       ramp_step_r       <= cfg_data[REG_W-1:0];
        CFG_LOW_SPEED_CAP:   low_speed_cap_r   <= cfg_data[REG_W-1:0];
        CFG_LOW_SPEED_LIMIT: low_speed_limit_r <= cfg_data[SPEED_W-1:0];
        CFG_CRUISE_CURRENT:  cruise_current_r  <= cfg_data[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_sw_r.key_on   <= in_key_on;
      in_sw_r.bms      <= bms_state_t'(in_bms_state);
      in_sw_r.regen    <= in_regen_brake;
      in_sw_r.brake    <= in_brake_pedal;
      in_sw_r.engage   <= in_cruise_engage;
      in_sw_r.up       <= in_cruise_up;
      in_sw_r.down     <= in_cruise_down;
      in_sw_r.fwd      <= in_drive_forward;
      in_sw_r.rev      <= in_drive_reverse;
      in_sw_r.tick     <= in_limit_tick;
      in_pedal_r       <= in_pedal_sample;
      in_speed_r       <= in_vehicle_speed;
    end
  end

  dmcr_step #(
    .PEDAL_BITS   (PEDAL_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_step (
    .sw                 (in_sw_r),
    .pedal_sample       (in_pedal_r),
    .vehicle_speed      (in_speed_r),
    .pedal_low          (pedal_low_r),
    .pedal_high         (pedal_high_r),
    .pedal_gain         (pedal_gain_r),
    .ramp_step          (ramp_step_r),
    .low_speed_cap      (low_speed_cap_r),
    .low_speed_limit    (low_speed_limit_r),
    .cruise_current     (cruise_current_r),
    .cruise_latched     (latched_r),
    .cruise_setpoint    (setpoint_r),
    .current_level      (cur_r),
    .previous_target    (prev_tgt_r),
    .speed_level        (spd_r),
    .cruise_latched_nxt (latched_nxt),
    .cruise_setpoint_nxt(setpoint_nxt),
    .current_level_nxt  (cur_nxt),
    .previous_target_nxt(prev_tgt_nxt),
    .speed_level_nxt    (spd_nxt),
    .inverter_mode      (inv_mode),
    .drive_mode         (dmode)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_r  <= 1'b0;
      setpoint_r <= '0;
      cur_r      <= '0;
      prev_tgt_r <= '0;
      spd_r      <= '0;
    end else if (move) begin
      latched_r  <= latched_nxt;
      setpoint_r <= setpoint_nxt;
      cur_r      <= cur_nxt;
      prev_tgt_r <= prev_tgt_nxt;
      spd_r      <= spd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // results carry the updated levels
  always_ff @(posedge clk) begin
    if (move) begin
      out_cur_ref         <= cur_nxt;
      out_motor_speed_ref <= spd_nxt;
      out_inverter_mode   <= inv_mode;
      out_drive_mode      <= dmode;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_vld_r && out_valid && !out_ready))
    else $error("input stalled while pipeline has room");

  a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_drive_mode == DM_OFF)) |->
    ((out_cur_ref == '0) && (out_motor_speed_ref == '0) &&
     (out_inverter_mode == INV_SAFE)))
    else $error("power-off word carries nonzero fields");

  a_ref_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cur_ref <= ONE_Q))
    else $error("current reference above one");

  a_precharge_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (move && in_sw_r.key_on &&
     ((in_sw_r.bms == BMS_IDLE) || (in_sw_r.bms == BMS_PRECHARGE))) |=>
    ((cur_r == $past(cur_r)) && (spd_r == $past(spd_r)) &&
     (setpoint_r == $past(setpoint_r))))
    else $error("drive state changed during precharge");

  a_setpoint_range: assert property (@(posedge clk) disable iff (!rst_n)
    setpoint_r <= SETPOINT_MAX)
    else $error("cruise setpoint out of range");

endmodule
